// ----- rtl/core/mrbo_pkg.sv -----
// shared types, codes and defaults for the mixed-radix basis operator block
package mrbo_pkg;

    // field widths fixed by the item formats
    localparam int IDX_W   = 32;
    localparam int SITE_W  = 4;
    localparam int COEF_W  = 7;
    localparam int STAT_W  = 2;
    localparam int SCNT_W  = 5;
    localparam int QNUM_W  = 7;
    localparam int CFG_A_W = 2;
    localparam int CFG_D_W = 7;

    // radix is at most 128, so one digit never needs more than 7 bits
    localparam int DIGIT_W = 7;
    localparam int RADIX_W = 8;
    localparam int CNT_W   = $clog2(IDX_W);

    // parameter defaults
    localparam int MAX_SITES_DEF  = 16;
    localparam int INDEX_BITS_DEF = 32;

    // request kinds
    localparam logic REQ_RAISE  = 1'b0;
    localparam logic REQ_NUMBER = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // register indexes
    localparam logic [CFG_A_W-1:0] CFG_SITE_COUNT  = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_QUANTUM_MIN = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_QUANTUM_MAX = 2'd2;

    typedef struct packed {
        logic              req_type;
        logic [IDX_W-1:0]  state_index;
        logic [SITE_W-1:0] site;
    } req_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coefficient;
        logic [IDX_W-1:0]         result_index;
        logic [STAT_W-1:0]        status;
    } rsp_t;

endpackage

// ----- rtl/core/mixed_radix_basis_ops.sv -----
// top level of the mixed-radix basis operator block
//
// A basis index is read as a number in base D = quantum_max - quantum_min + 1, one digit
// per site, site 0 least significant. A raise transfer returns coefficient 1 and
// index + D^site, or the null index D^site_count when the digit is already D-1; a number
// transfer returns quantum_min + digit with the index unchanged. Range problems come back
// in status with coefficient and index zero. One item is in flight at a time: in_stall is
// high from the accept until the result is loaded into the output register, which frees
// the input while that result waits for the receiver. An item runs the power sweep (one
// multiply by D per cycle), then restoring division over the 32 index bits (one index bit
// per cycle on the shared subtractor), then splits off the digit; items that fail a range
// check finish early. The user must write configuration only while no item is in flight;
// the block itself does not enforce it.
module mixed_radix_basis_ops #(
    parameter int MAX_SITES  = mrbo_pkg::MAX_SITES_DEF,
    parameter int INDEX_BITS = mrbo_pkg::INDEX_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [mrbo_pkg::CFG_A_W-1:0] cfg_index,
    input  logic [mrbo_pkg::CFG_D_W-1:0] cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  mrbo_pkg::req_t               in_item,
    output logic                         out_valid,
    input  logic                         out_stall,
    output mrbo_pkg::rsp_t               out_item
);

    localparam int IW  = INDEX_BITS;
    localparam int SW  = ((IW > mrbo_pkg::IDX_W) ? IW : mrbo_pkg::IDX_W) + 8;
    localparam int KW  = (MAX_SITES > 1) ? $clog2(MAX_SITES + 1) : 1;
    localparam int PW  = IW + mrbo_pkg::RADIX_W;
    localparam int DW  = mrbo_pkg::DIGIT_W;
    localparam int CW  = mrbo_pkg::CNT_W;

    // sequencer codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_POW   = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_DIG   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // configuration
    logic [mrbo_pkg::SCNT_W-1:0] sc_reg;
    logic [mrbo_pkg::QNUM_W-1:0] qmin_reg;
    logic [mrbo_pkg::QNUM_W-1:0] qmax_reg;

    // control
    logic [2:0]    state_reg, state_next;
    logic          out_valid_reg, out_valid_next;

    // item work registers
    logic                            req_reg, req_next;
    logic [mrbo_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic [mrbo_pkg::IDX_W-1:0]      sh_reg, sh_next;
    logic [mrbo_pkg::SITE_W-1:0]     site_reg, site_next;
    logic [mrbo_pkg::RADIX_W-1:0]    d_reg, d_next;
    logic [IW-1:0]                   pow_reg, pow_next;
    logic [IW-1:0]                   place_reg, place_next;
    logic [IW-1:0]                   pnext_reg, pnext_next;
    logic [KW-1:0]                   k_reg, k_next;
    logic [SW-1:0]                   rem_reg, rem_next;
    logic [SW-1:0]                   dv_reg, dv_next;
    logic [DW-1:0]                   digit_reg, digit_next;
    logic [CW-1:0]                   cnt_reg, cnt_next;
    logic [mrbo_pkg::STAT_W-1:0]     stat_reg, stat_next;
    mrbo_pkg::rsp_t                  out_reg, out_next;

    // quantum range and radix
    logic [mrbo_pkg::RADIX_W-1:0] qdiff;
    logic                         range_empty;
    logic                         count_bad;

    // power sweep multiplier
    logic [PW-1:0] prod;
    logic          prod_ovf;

    // shared subtract / compare unit
    logic [SW-1:0] unit_a;
    logic [SW-1:0] unit_b;
    logic [SW:0]   unit_diff;
    logic          unit_ge;
    logic [SW-1:0] div_shift;

    // result formation
    logic                          raise_ok;
    logic [SW-1:0]                 raise_sum;
    logic                          out_free;

    assign qdiff = {qmax_reg[mrbo_pkg::QNUM_W-1], qmax_reg}
                 - {qmin_reg[mrbo_pkg::QNUM_W-1], qmin_reg};
    assign range_empty = qdiff[mrbo_pkg::RADIX_W-1];
    assign count_bad   = (sc_reg == '0) || (32'(sc_reg) > MAX_SITES);

    assign prod     = PW'(pow_reg) * PW'(d_reg);
    assign prod_ovf = (prod[PW-1:IW] != '0);

    // next remainder candidate while stepping through the index bits
    assign div_shift = {rem_reg[SW-2:0], sh_reg[mrbo_pkg::IDX_W-1]};

    always_comb
    begin
        unique case (state_reg)
            S_CHECK:
            begin
                unit_a = SW'(idx_reg);
                unit_b = SW'(pow_reg);
            end
            S_DIV:
            begin
                unit_a = div_shift;
                unit_b = SW'(pnext_reg);
            end
            default:
            begin
                unit_a = rem_reg;
                unit_b = dv_reg;
            end
        endcase
    end

    assign unit_diff = {1'b0, unit_a} - {1'b0, unit_b};
    assign unit_ge   = ~unit_diff[SW];

    assign raise_ok  = (({1'b0, digit_reg} + 8'd1) < d_reg);
    assign raise_sum = SW'(idx_reg) + SW'(place_reg);
    assign out_free  = ~out_valid_reg | ~out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        req_next       = req_reg;
        idx_next       = idx_reg;
        sh_next        = sh_reg;
        site_next      = site_reg;
        d_next         = d_reg;
        pow_next       = pow_reg;
        place_next     = place_reg;
        pnext_next     = pnext_reg;
        k_next         = k_reg;
        rem_next       = rem_reg;
        dv_next        = dv_reg;
        digit_next     = digit_reg;
        cnt_next       = cnt_reg;
        stat_next      = stat_reg;
        out_next       = out_reg;

        // receiver took the pending result
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = in_item.req_type;
                    idx_next   = in_item.state_index;
                    sh_next    = in_item.state_index;
                    site_next  = in_item.site;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                d_next    = qdiff + 8'd1;
                pow_next  = IW'(1);
                k_next    = '0;
                stat_next = mrbo_pkg::ST_OK;
                priority if (range_empty)
                begin
                    stat_next  = mrbo_pkg::ST_EMPTY;
                    state_next = S_DONE;
                end
                else if (count_bad)
                begin
                    stat_next  = mrbo_pkg::ST_RANGE;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_POW;
                end
            end
            S_POW:
            begin
                // pow holds D^k; grab D^site and D^(site+1) on the way up
                if (8'(k_reg) == 8'(site_reg))
                begin
                    place_next = pow_reg;
                end
                if (8'(k_reg) == (8'(site_reg) + 8'd1))
                begin
                    pnext_next = pow_reg;
                end
                priority if (8'(k_reg) == 8'(sc_reg))
                begin
                    state_next = S_CHECK;
                end
                else if (prod_ovf)
                begin
                    stat_next  = mrbo_pkg::ST_RANGE;
                    state_next = S_DONE;
                end
                else
                begin
                    pow_next = prod[IW-1:0];
                    k_next   = k_reg + KW'(1);
                end
            end
            S_CHECK:
            begin
                // index against D^site_count, site against site_count
                if (unit_ge || (5'(site_reg) >= sc_reg))
                begin
                    stat_next  = mrbo_pkg::ST_RANGE;
                    state_next = S_DONE;
                end
                else
                begin
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // index mod D^(site+1), one bit per cycle
                rem_next = unit_ge ? unit_diff[SW-1:0] : div_shift;
                sh_next  = {sh_reg[mrbo_pkg::IDX_W-2:0], 1'b0};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(mrbo_pkg::IDX_W - 1))
                begin
                    dv_next    = SW'(place_reg) << (DW - 1);
                    cnt_next   = '0;
                    digit_next = '0;
                    state_next = S_DIG;
                end
            end
            S_DIG:
            begin
                // remainder / D^site, short quotient below 128
                if (unit_ge)
                begin
                    rem_next = unit_diff[SW-1:0];
                end
                digit_next = {digit_reg[DW-2:0], unit_ge};
                dv_next    = dv_reg >> 1;
                cnt_next   = cnt_reg + CW'(1);
                if (cnt_reg == CW'(DW - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_next.status = stat_reg;
                    if (stat_reg != mrbo_pkg::ST_OK)
                    begin
                        out_next.coefficient  = '0;
                        out_next.result_index = '0;
                    end
                    else if (req_reg == mrbo_pkg::REQ_RAISE)
                    begin
                        out_next.coefficient  = 7'sd1;
                        out_next.result_index = raise_ok
                                              ? raise_sum[mrbo_pkg::IDX_W-1:0]
                                              : mrbo_pkg::IDX_W'(pow_reg);
                    end
                    else
                    begin
                        out_next.coefficient  = qmin_reg + digit_reg;
                        out_next.result_index = idx_reg;
                    end
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            sc_reg        <= 5'd1;
            qmin_reg      <= '0;
            qmax_reg      <= 7'd1;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    mrbo_pkg::CFG_SITE_COUNT:  sc_reg   <= cfg_data[mrbo_pkg::SCNT_W-1:0];
                    mrbo_pkg::CFG_QUANTUM_MIN: qmin_reg <= cfg_data;
                    mrbo_pkg::CFG_QUANTUM_MAX: qmax_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        idx_reg   <= idx_next;
        sh_reg    <= sh_next;
        site_reg  <= site_next;
        d_reg     <= d_next;
        pow_reg   <= pow_next;
        place_reg <= place_next;
        pnext_reg <= pnext_next;
        k_reg     <= k_next;
        rem_reg   <= rem_next;
        dv_reg    <= dv_next;
        digit_reg <= digit_next;
        cnt_reg   <= cnt_next;
        stat_reg  <= stat_next;
        out_reg   <= out_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// ----- sim/tb_top.sv -----
// self-checking testbench for the mixed-radix basis operator block
`timescale 1ns / 1ps

import mrbo_pkg::*;

// keeps a private copy of the registers and the queue of predicted results
class basis_op_tracker;
    localparam longint unsigned INDEX_MAX = 64'hFFFF_FFFF;

    rsp_t              expected_rsp[$];
    logic [4:0]        sites;
    logic signed [6:0] q_lo;
    logic signed [6:0] q_hi;
    int unsigned       failures;

    function new();
        sites    = 5'd1;
        q_lo     = 7'sd0;
        q_hi     = 7'sd1;
        failures = 0;
    endfunction

    function void apply_write(logic [CFG_A_W-1:0] idx, logic [CFG_D_W-1:0] data);
        case (idx)
            CFG_SITE_COUNT:  sites = data[4:0];
            CFG_QUANTUM_MIN: q_lo  = data;
            CFG_QUANTUM_MAX: q_hi  = data;
            default: ;
        endcase
    endfunction

    // d^n, refused once it would pass the largest index value
    function bit raise_power(longint unsigned d, int n, output longint unsigned p);
        longint unsigned acc;
        int              i;
        acc = 1;
        p   = 0;
        for (i = 0; i < n; i++)
        begin
            if (acc > INDEX_MAX / d)
                return 1'b0;
            acc = acc * d;
        end
        p = acc;
        return 1'b1;
    endfunction

    // radix, zero for an empty quantum range
    function longint unsigned radix();
        if (q_hi < q_lo)
            return 0;
        return longint'(int'(q_hi) - int'(q_lo) + 1);
    endfunction

    // number of valid indexes, zero when no index is valid
    function longint unsigned span();
        longint unsigned d;
        longint unsigned p;
        d = radix();
        if (d == 0 || sites == 0 || sites > MAX_SITES_DEF)
            return 0;
        if (!raise_power(d, int'(sites), p))
            return 0;
        return p;
    endfunction

    function rsp_t predict(req_t r);
        rsp_t            e;
        longint unsigned d;
        longint unsigned total;
        longint unsigned place;
        longint unsigned digit;
        e = '0;
        d = radix();
        if (d == 0)
        begin
            e.status = ST_EMPTY;
            return e;
        end
        total = span();
        if (total == 0 || r.state_index >= total || r.site >= sites)
        begin
            e.status = ST_RANGE;
            return e;
        end
        void'(raise_power(d, int'(r.site), place));
        digit    = (r.state_index / place) % d;
        e.status = ST_OK;
        if (r.req_type == REQ_RAISE)
        begin
            e.coefficient  = 7'sd1;
            e.result_index = (digit + 1 < d) ? 32'(r.state_index + place) : 32'(total);
        end
        else
        begin
            e.coefficient  = 7'(int'(q_lo) + int'(digit));
            e.result_index = r.state_index;
        end
        return e;
    endfunction

    function void note_request(req_t r);
        expected_rsp = {expected_rsp, predict(r)};
    endfunction

    function void check_response(rsp_t a);
        rsp_t e;
        bit   bad;
        if (expected_rsp.size() == 0)
        begin
            failures++;
            $display("%0t: result with nothing expected: coef %0d index %0h status %0d",
                     $time, a.coefficient, a.result_index, a.status);
            return;
        end
        e   = expected_rsp.pop_front();
        bad = 1'b0;
        if (a.coefficient !== e.coefficient)
        begin
            bad = 1'b1;
            $display("%0t: coefficient expected %0d actual %0d",
                     $time, e.coefficient, a.coefficient);
        end
        if (a.result_index !== e.result_index)
        begin
            bad = 1'b1;
            $display("%0t: result_index expected %0h actual %0h",
                     $time, e.result_index, a.result_index);
        end
        if (a.status !== e.status)
        begin
            bad = 1'b1;
            $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
        end
        if (bad)
            failures++;
    endfunction

    function int pending();
        return expected_rsp.size();
    endfunction
endclass

module tb_top;

    localparam int PHASES      = 16;
    localparam int PHASE_ITEMS = 120;
    // wait after the final drain, before the verdict
    localparam int TAIL_CYCLES = 64;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [CFG_A_W-1:0] cfg_index = '0;
    logic [CFG_D_W-1:0] cfg_data  = '0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    req_t               in_item   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    rsp_t               out_item;

    basis_op_tracker tracker;
    // set for stretches where neither side idles
    bit no_idle = 1'b0;
    // set when a drain wait ran out
    bit stuck   = 1'b0;

    mixed_radix_basis_ops i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // sample everything on the edge: register writes, input and output transfers
    always @(posedge clk)
    begin
        if (rst_n && tracker != null)
        begin
            if (cfg_we)
                tracker.apply_write(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                tracker.note_request(in_item);
            if (out_valid && !out_stall)
                tracker.check_response(out_item);
        end
    end

    // receiver: per result, stall or not at random, then take the next transfer
    initial
    begin : receiver
        int n;
        forever
        begin
            n = no_idle ? 0 : $urandom_range(0, 5);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(rst_n && out_valid));
        end
    end

    // hard stop well past the slowest correct run
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // one input transfer, after a random gap; valid stays high on return
    task automatic send_request(req_t r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= r;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_fields(logic kind, logic [IDX_W-1:0] idx, logic [SITE_W-1:0] site);
        req_t r;
        r.req_type    = kind;
        r.state_index = idx;
        r.site        = site;
        send_request(r);
    endtask

    // stop sending and wait until every predicted result has come back
    task automatic settle();
        int guard;
        in_valid <= 1'b0;
        @(posedge clk);
        guard = 0;
        while (tracker.pending() != 0 && guard < 4000)
        begin
            @(posedge clk);
            guard++;
        end
        if (tracker.pending() != 0)
        begin
            stuck = 1'b1;
            $display("%0t: %0d results still expected", $time, tracker.pending());
        end
    endtask

    // write all three registers in turn, then drop cfg_we
    task automatic write_config(logic [CFG_D_W-1:0] sc, logic [CFG_D_W-1:0] lo,
                                logic [CFG_D_W-1:0] hi);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SITE_COUNT;
        cfg_data  <= sc;
        @(posedge clk);
        cfg_index <= CFG_QUANTUM_MIN;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= CFG_QUANTUM_MAX;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reconfigure(logic [CFG_D_W-1:0] sc, logic [CFG_D_W-1:0] lo,
                               logic [CFG_D_W-1:0] hi);
        settle();
        write_config(sc, lo, hi);
    endtask

    // mostly indexes built digit by digit under the current setting, the rest noise or just out of range
    function automatic req_t shaped_request();
        req_t            r;
        longint unsigned total;
        longint unsigned d;
        longint unsigned idx;
        longint unsigned place;
        int              k;
        int              dig;
        total         = tracker.span();
        d             = tracker.radix();
        r.req_type    = 1'($urandom_range(0, 1));
        r.site        = 4'($urandom_range(0, 15));
        r.state_index = $urandom;
        if (total != 0 && $urandom_range(0, 9) < 8)
        begin
            idx   = 0;
            place = 1;
            for (k = 0; k < int'(tracker.sites); k++)
            begin
                // lean on the lowest and highest digit so raises hit the null case
                case ($urandom_range(0, 3))
                    0:       dig = 0;
                    1:       dig = int'(d) - 1;
                    default: dig = $urandom_range(0, int'(d) - 1);
                endcase
                idx   = idx + longint'(dig) * place;
                place = place * d;
            end
            r.state_index = 32'(idx);
            r.site        = 4'($urandom_range(0, int'(tracker.sites) - 1));
        end
        else if (total != 0 && $urandom_range(0, 1) == 1)
        begin
            // just past the top of the index space, or one site past the last
            if ($urandom_range(0, 1) == 1 || tracker.sites >= 5'd16)
                r.state_index = 32'(total + $urandom_range(0, 2));
            else
                r.site = 4'(tracker.sites);
        end
        return r;
    endfunction

    initial
    begin : stimulus
        int                p;
        int                i;
        int                sc;
        int                d;
        int                lo;
        longint unsigned   pw;
        tracker = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: reset setting, one site of base 2
        send_fields(REQ_RAISE, 32'd0, 4'd0);
        send_fields(REQ_RAISE, 32'd1, 4'd0);
        send_fields(REQ_NUMBER, 32'd0, 4'd0);
        send_fields(REQ_NUMBER, 32'd1, 4'd0);
        send_fields(REQ_RAISE, 32'd2, 4'd0);
        send_fields(REQ_NUMBER, 32'd0, 4'd1);
        send_fields(REQ_RAISE, 32'hFFFF_FFFF, 4'd15);

        // widest radix, top digit full
        reconfigure(7'd4, 7'h40, 7'h3F);
        send_fields(REQ_RAISE, 32'h0FFF_FFFF, 4'd3);
        send_fields(REQ_NUMBER, 32'h0FFF_FFFF, 4'd3);
        send_fields(REQ_NUMBER, 32'd0, 4'd0);
        send_fields(REQ_RAISE, 32'd0, 4'd3);

        // single-valued site: every in-range raise gives the null index
        reconfigure(7'd16, 7'd5, 7'd5);
        send_fields(REQ_RAISE, 32'd0, 4'd15);
        send_fields(REQ_NUMBER, 32'd0, 4'd7);
        send_fields(REQ_RAISE, 32'd1, 4'd0);

        // dimension exactly 2^32, one past the largest index
        reconfigure(7'd16, 7'd0, 7'd3);
        send_fields(REQ_NUMBER, 32'd0, 4'd0);

        // zero sites
        reconfigure(7'd0, 7'd0, 7'd1);
        send_fields(REQ_RAISE, 32'd0, 4'd0);

        // empty quantum range
        reconfigure(7'd3, 7'd10, 7'd2);
        send_fields(REQ_NUMBER, 32'd0, 4'd0);

        // base 3 over all sixteen sites, largest valid index
        reconfigure(7'd16, 7'h7F, 7'd1);
        send_fields(REQ_RAISE, 32'd43046720, 4'd15);
        send_fields(REQ_NUMBER, 32'd43046720, 4'd15);

        // random phases, each under its own setting
        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0:  reconfigure(7'd16, 7'd0, 7'd1);
                1:  reconfigure(7'd1, 7'h40, 7'h3F);
                2:  reconfigure(7'd4, 7'h40, 7'h3F);
                3:  reconfigure(7'd5, 7'h40, 7'h3F);
                4:  reconfigure(7'd16, 7'h7F, 7'd1);
                5:  reconfigure(7'd16, 7'd7, 7'd7);
                6:  reconfigure(7'd15, 7'd0, 7'd3);
                7:  reconfigure(7'd8, 7'h78, 7'd7);
                default:
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        // anything the register widths allow
                        reconfigure(7'($urandom), 7'($urandom), 7'($urandom));
                    end
                    else
                    begin
                        // a valid setting whose random radix is cut down until it fits
                        sc = $urandom_range(1, 16);
                        d  = $urandom_range(1, 128);
                        while (!tracker.raise_power(longint'(d), sc, pw))
                            d--;
                        lo = $urandom_range(0, 128 - d) - 64;
                        reconfigure(7'(sc), 7'(lo), 7'(lo + d - 1));
                    end
                end
            endcase
            no_idle = (p % 5 == 2);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                send_request(shaped_request());
                // now and then hold off until the block has drained
                if ($urandom_range(0, 79) == 0)
                    settle();
            end
        end
        no_idle = 1'b0;

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.failures == 0 && tracker.pending() == 0 && !stuck)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- mixed_radix_basis_ops.f -----
rtl/core/mrbo_pkg.sv
rtl/core/mixed_radix_basis_ops.sv
sim/tb_top.sv
